// ===== hw/rtl/cbb_pkg.sv =====
// Shared widths, types and constants for the cubic Bezier bounding box block.
`default_nettype none
package cbb_pkg;

    // Coordinate and parameter formats
    localparam int CW   = 16;             // coordinate width, Q12.4 raw
    localparam int PF   = 16;             // fraction bits of t
    localparam int SF   = 12;             // fraction bits of the square root

    // Coefficient widths
    localparam int AW   = CW + 3;         // end - 3*cb + 3*ca - start
    localparam int BW   = CW + 2;         // cb - 2*ca + start
    localparam int CCW  = CW + 1;         // ca - start
    localparam int PRW  = 2 * BW;         // B*B and A*C products
    localparam int DW   = PRW + 1;        // discriminant

    // Square root
    localparam int XW   = DW - 1 + 2 * SF; // radicand
    localparam int RTW  = XW / 2;          // root
    localparam int REMW = RTW + 2;         // partial remainder

    // Root division
    localparam int NQW  = RTW + 2;         // -B*g +- s
    localparam int NW   = NQW + PF;        // dividend
    localparam int DNW  = AW + SF;         // divisor
    localparam int QW   = PF + 1;          // quotient, 0 .. 1.0 and one spare bit

    // de Casteljau product width
    localparam int PW   = CW + 1 + QW + 1;

    localparam logic [QW-1:0] T_ONE = QW'(1 << PF);

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t                 p0;
        coord_t                 p1;
        coord_t                 p2;
        coord_t                 p3;
        logic signed [AW-1:0]   a;
        logic signed [BW-1:0]   b;
        logic signed [CCW-1:0]  c;
    } curve_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cbb_if.sv =====
// Valid/ready channel interfaces for curve input words and box output words.
`default_nettype none
interface cbb_curve_if;
    logic            valid;
    logic            ready;
    cbb_pkg::coord_t start_x;
    cbb_pkg::coord_t start_y;
    cbb_pkg::coord_t ctrl_a_x;
    cbb_pkg::coord_t ctrl_a_y;
    cbb_pkg::coord_t ctrl_b_x;
    cbb_pkg::coord_t ctrl_b_y;
    cbb_pkg::coord_t end_x;
    cbb_pkg::coord_t end_y;

    modport source (
        output valid, start_x, start_y, ctrl_a_x, ctrl_a_y,
               ctrl_b_x, ctrl_b_y, end_x, end_y,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, ctrl_a_x, ctrl_a_y,
               ctrl_b_x, ctrl_b_y, end_x, end_y,
        output ready
    );
endinterface

interface cbb_box_if;
    logic            valid;
    logic            ready;
    cbb_pkg::coord_t box_min_x;
    cbb_pkg::coord_t box_min_y;
    cbb_pkg::coord_t box_max_x;
    cbb_pkg::coord_t box_max_y;

    modport source (
        output valid, box_min_x, box_min_y, box_max_x, box_max_y,
        input  ready
    );
    modport sink (
        input  valid, box_min_x, box_min_y, box_max_x, box_max_y,
        output ready
    );
endinterface
`default_nettype wire

// ===== hw/rtl/cbb_axis.sv =====
// One-axis extremum pipeline: coefficients, square root, root division, curve evaluation.
`default_nettype none
module cbb_axis (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vld_in,
    input  cbb_pkg::coord_t p0,
    input  cbb_pkg::coord_t p1,
    input  cbb_pkg::coord_t p2,
    input  cbb_pkg::coord_t p3,
    output logic            vld_out,
    output cbb_pkg::coord_t lo,
    output cbb_pkg::coord_t hi
);

    // (b - a) * t, full precision
    function automatic logic signed [cbb_pkg::PW-1:0] dmul(
        cbb_pkg::coord_t a, cbb_pkg::coord_t b, logic [cbb_pkg::QW-1:0] t);
        logic signed [cbb_pkg::CW:0] d;
        d = (cbb_pkg::CW+1)'(b) - (cbb_pkg::CW+1)'(a);
        return d * $signed({1'b0, t});
    endfunction

    // a + floor(m / 2^PF)
    function automatic cbb_pkg::coord_t ladd(cbb_pkg::coord_t a,
                                             logic signed [cbb_pkg::PW-1:0] m);
        logic signed [cbb_pkg::PW-cbb_pkg::PF-1:0] s;
        s = (cbb_pkg::PW-cbb_pkg::PF)'(a) + $signed(m[cbb_pkg::PW-1:cbb_pkg::PF]);
        return cbb_pkg::CW'(s);
    endfunction

    // ---------------- stage 1: coefficients
    logic signed [cbb_pkg::AW-1:0] e0, e1, e2, e3;
    cbb_pkg::curve_t s1_next;
    cbb_pkg::curve_t s1_cv_reg;
    logic            s1_vld_reg;

    assign e0 = cbb_pkg::AW'(p0);
    assign e1 = cbb_pkg::AW'(p1);
    assign e2 = cbb_pkg::AW'(p2);
    assign e3 = cbb_pkg::AW'(p3);

    always_comb
    begin
        s1_next.p0 = p0;
        s1_next.p1 = p1;
        s1_next.p2 = p2;
        s1_next.p3 = p3;
        s1_next.a  = e3 - ((e2 <<< 1) + e2) + ((e1 <<< 1) + e1) - e0;
        s1_next.b  = cbb_pkg::BW'(e2 - (e1 <<< 1) + e0);
        s1_next.c  = cbb_pkg::CCW'(e1 - e0);
    end

    // ---------------- stage 2: products, stage 3: discriminant
    logic signed [cbb_pkg::PRW-1:0] s2_bb_reg, s2_ac_reg;
    cbb_pkg::curve_t                s2_cv_reg;
    logic                           s2_vld_reg;
    logic signed [cbb_pkg::DW-1:0]  s3_d_reg;
    cbb_pkg::curve_t                s3_cv_reg;
    logic                           s3_vld_reg;

    // ---------------- square root, one result bit per stage
    logic [cbb_pkg::XW-1:0]   x0;
    logic                     ok0, lin0;
    logic [cbb_pkg::XW-1:0]   sq_x_next   [cbb_pkg::RTW];
    logic [cbb_pkg::REMW-1:0] sq_rem_next [cbb_pkg::RTW];
    logic [cbb_pkg::RTW-1:0]  sq_rt_next  [cbb_pkg::RTW];
    logic [cbb_pkg::XW-1:0]   sq_x_reg    [cbb_pkg::RTW];
    logic [cbb_pkg::REMW-1:0] sq_rem_reg  [cbb_pkg::RTW];
    logic [cbb_pkg::RTW-1:0]  sq_rt_reg   [cbb_pkg::RTW];
    cbb_pkg::curve_t          sq_cv_reg   [cbb_pkg::RTW];
    logic                     sq_ok_reg   [cbb_pkg::RTW];
    logic                     sq_lin_reg  [cbb_pkg::RTW];
    logic                     sq_vld_reg  [cbb_pkg::RTW];

    // negative discriminant feeds zero and the roots are dropped anyway
    assign x0   = s3_d_reg[cbb_pkg::DW-1] ? '0 :
                  {s3_d_reg[cbb_pkg::XW-2*cbb_pkg::SF-1:0], {(2*cbb_pkg::SF){1'b0}}};
    assign ok0  = (s3_cv_reg.a != '0) && !s3_d_reg[cbb_pkg::DW-1];
    assign lin0 = (s3_cv_reg.a == '0) && (s3_cv_reg.b != '0);

    for (genvar j = 0; j < cbb_pkg::RTW; j++)
    begin : g_sq
        logic [cbb_pkg::XW-1:0]   xi;
        logic [cbb_pkg::REMW-1:0] ri;
        logic [cbb_pkg::RTW-1:0]  qi;
        logic [cbb_pkg::REMW+1:0] cur;
        logic [cbb_pkg::REMW+1:0] trial;
        logic                     ge;
        if (j == 0)
        begin : g_first
            assign xi = x0;
            assign ri = '0;
            assign qi = '0;
        end
        else
        begin : g_rest
            assign xi = sq_x_reg[j-1];
            assign ri = sq_rem_reg[j-1];
            assign qi = sq_rt_reg[j-1];
        end
        assign cur            = {ri, xi[cbb_pkg::XW-1 -: 2]};
        assign trial          = {{(cbb_pkg::REMW-cbb_pkg::RTW){1'b0}}, qi, 2'b01};
        assign ge             = cur >= trial;
        assign sq_rem_next[j] = ge ? cbb_pkg::REMW'(cur - trial) : cur[cbb_pkg::REMW-1:0];
        assign sq_rt_next[j]  = {qi[cbb_pkg::RTW-2:0], ge};
        assign sq_x_next[j]   = xi << 2;
    end

    // ---------------- root numerators and divisors
    localparam int SQL = cbb_pkg::RTW - 1;
    cbb_pkg::curve_t               rc;
    logic signed [cbb_pkg::NQW-1:0] bsh, sx, n1, n2;
    logic signed [cbb_pkg::DNW-1:0] den;
    logic signed [cbb_pkg::NW-1:0]  rn_n_next [2];
    logic signed [cbb_pkg::DNW-1:0] rn_d_next [2];
    logic signed [cbb_pkg::NW-1:0]  rn_n_reg  [2];
    logic signed [cbb_pkg::DNW-1:0] rn_d_reg  [2];
    logic                           rn_v_reg  [2];
    cbb_pkg::curve_t                rn_cv_reg;
    logic                           rn_vld_reg;

    assign rc  = sq_cv_reg[SQL];
    assign bsh = cbb_pkg::NQW'(rc.b) <<< cbb_pkg::SF;
    assign sx  = $signed(cbb_pkg::NQW'(sq_rt_reg[SQL]));
    assign n1  = -bsh - sx;
    assign n2  = -bsh + sx;
    assign den = cbb_pkg::DNW'(rc.a) <<< cbb_pkg::SF;

    // first divider also serves the linear root when A is zero
    assign rn_n_next[0] = sq_ok_reg[SQL] ? (cbb_pkg::NW'(n1) <<< cbb_pkg::PF)
                                         : (-(cbb_pkg::NW'(rc.c)) <<< cbb_pkg::PF);
    assign rn_d_next[0] = sq_ok_reg[SQL] ? den : (cbb_pkg::DNW'(rc.b) <<< 1);
    assign rn_n_next[1] = cbb_pkg::NW'(n2) <<< cbb_pkg::PF;
    assign rn_d_next[1] = den;

    // ---------------- magnitudes and quotient sign
    logic [cbb_pkg::NW-1:0]  ra_num_reg [2];
    logic [cbb_pkg::DNW-1:0] ra_den_reg [2];
    logic                    ra_neg_reg [2];
    logic                    ra_v_reg   [2];
    cbb_pkg::curve_t         ra_cv_reg;
    logic                    ra_vld_reg;

    // ---------------- restoring division, range check then one bit per stage
    localparam int DVS = cbb_pkg::QW + 1;
    logic [cbb_pkg::NW-1:0]  dv_rem_next [2][DVS];
    logic [cbb_pkg::QW-1:0]  dv_q_next   [2][DVS];
    logic                    dv_ok_next  [2][DVS];
    logic [cbb_pkg::NW-1:0]  dv_rem_reg  [2][DVS];
    logic [cbb_pkg::DNW-1:0] dv_den_reg  [2][DVS];
    logic [cbb_pkg::QW-1:0]  dv_q_reg    [2][DVS];
    logic                    dv_ok_reg   [2][DVS];
    logic                    dv_neg_reg  [2][DVS];
    cbb_pkg::curve_t         dv_cv_reg   [DVS];
    logic                    dv_vld_reg  [DVS];

    for (genvar r = 0; r < 2; r++)
    begin : g_dv
        for (genvar k = 0; k < DVS; k++)
        begin : g_stage
            if (k == 0)
            begin : g_range
                // quotient above 2^QW - 1 is out of range
                assign dv_rem_next[r][k] = ra_num_reg[r];
                assign dv_q_next[r][k]   = '0;
                assign dv_ok_next[r][k]  = ra_v_reg[r] &&
                    !(ra_num_reg[r] >= {ra_den_reg[r], {cbb_pkg::QW{1'b0}}});
            end
            else
            begin : g_bit
                logic [cbb_pkg::NW-1:0] sh;
                logic                   ge;
                assign sh = cbb_pkg::NW'(dv_den_reg[r][k-1]) << (cbb_pkg::QW - k);
                assign ge = dv_rem_reg[r][k-1] >= sh;
                assign dv_rem_next[r][k] = ge ? dv_rem_reg[r][k-1] - sh
                                              : dv_rem_reg[r][k-1];
                assign dv_q_next[r][k]   = dv_q_reg[r][k-1] |
                                           (cbb_pkg::QW'(ge) << (cbb_pkg::QW - k));
                assign dv_ok_next[r][k]  = dv_ok_reg[r][k-1];
            end
        end
    end

    // ---------------- parameter range check
    logic [cbb_pkg::QW-1:0] tt_t_reg  [2];
    logic                   tt_ok_reg [2];
    cbb_pkg::curve_t        tt_cv_reg;
    logic                   tt_vld_reg;

    // ---------------- de Casteljau, multiply and add stages alternate
    localparam int EVS = 6;
    logic signed [cbb_pkg::PW-1:0] e1_m_reg [2][3];
    cbb_pkg::coord_t               e2_c_reg [2][3];
    logic signed [cbb_pkg::PW-1:0] e3_m_reg [2][2];
    cbb_pkg::coord_t               e3_a_reg [2];
    cbb_pkg::coord_t               e3_b_reg [2];
    cbb_pkg::coord_t               e4_d_reg [2];
    cbb_pkg::coord_t               e4_e_reg [2];
    logic signed [cbb_pkg::PW-1:0] e5_m_reg [2];
    cbb_pkg::coord_t               e5_d_reg [2];
    cbb_pkg::coord_t               e6_v_reg [2];
    logic [cbb_pkg::QW-1:0]        ev_t_reg  [2][EVS];
    logic                          ev_ok_reg [2][EVS];
    cbb_pkg::curve_t               ev_cv_reg [EVS];
    logic                          ev_vld_reg [EVS];

    // ---------------- fold
    cbb_pkg::coord_t lo_next, hi_next;
    cbb_pkg::coord_t lo_reg, hi_reg;
    logic            vld_reg;

    always_comb
    begin
        lo_next = (ev_cv_reg[EVS-1].p0 < ev_cv_reg[EVS-1].p3) ? ev_cv_reg[EVS-1].p0
                                                               : ev_cv_reg[EVS-1].p3;
        hi_next = (ev_cv_reg[EVS-1].p0 < ev_cv_reg[EVS-1].p3) ? ev_cv_reg[EVS-1].p3
                                                               : ev_cv_reg[EVS-1].p0;
        for (int r = 0; r < 2; r++)
        begin
            if (ev_ok_reg[r][EVS-1] && (e6_v_reg[r] < lo_next))
                lo_next = e6_v_reg[r];
            if (ev_ok_reg[r][EVS-1] && (e6_v_reg[r] > hi_next))
                hi_next = e6_v_reg[r];
        end
    end

    // ---------------- valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            for (int j = 0; j < cbb_pkg::RTW; j++)
                sq_vld_reg[j] <= 1'b0;
            rn_vld_reg <= 1'b0;
            ra_vld_reg <= 1'b0;
            for (int k = 0; k < DVS; k++)
                dv_vld_reg[k] <= 1'b0;
            tt_vld_reg <= 1'b0;
            for (int e = 0; e < EVS; e++)
                ev_vld_reg[e] <= 1'b0;
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= vld_in;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            sq_vld_reg[0] <= s3_vld_reg;
            for (int j = 1; j < cbb_pkg::RTW; j++)
                sq_vld_reg[j] <= sq_vld_reg[j-1];
            rn_vld_reg <= sq_vld_reg[SQL];
            ra_vld_reg <= rn_vld_reg;
            dv_vld_reg[0] <= ra_vld_reg;
            for (int k = 1; k < DVS; k++)
                dv_vld_reg[k] <= dv_vld_reg[k-1];
            tt_vld_reg <= dv_vld_reg[DVS-1];
            ev_vld_reg[0] <= tt_vld_reg;
            for (int e = 1; e < EVS; e++)
                ev_vld_reg[e] <= ev_vld_reg[e-1];
            vld_reg <= ev_vld_reg[EVS-1];
        end
    end

    // ---------------- data path
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cv_reg <= s1_next;
            s2_bb_reg <= s1_cv_reg.b * s1_cv_reg.b;
            s2_ac_reg <= s1_cv_reg.a * s1_cv_reg.c;
            s2_cv_reg <= s1_cv_reg;
            s3_d_reg  <= cbb_pkg::DW'(s2_bb_reg) - cbb_pkg::DW'(s2_ac_reg);
            s3_cv_reg <= s2_cv_reg;

            for (int j = 0; j < cbb_pkg::RTW; j++)
            begin
                sq_x_reg[j]   <= sq_x_next[j];
                sq_rem_reg[j] <= sq_rem_next[j];
                sq_rt_reg[j]  <= sq_rt_next[j];
            end
            sq_cv_reg[0]  <= s3_cv_reg;
            sq_ok_reg[0]  <= ok0;
            sq_lin_reg[0] <= lin0;
            for (int j = 1; j < cbb_pkg::RTW; j++)
            begin
                sq_cv_reg[j]  <= sq_cv_reg[j-1];
                sq_ok_reg[j]  <= sq_ok_reg[j-1];
                sq_lin_reg[j] <= sq_lin_reg[j-1];
            end

            for (int r = 0; r < 2; r++)
            begin
                rn_n_reg[r] <= rn_n_next[r];
                rn_d_reg[r] <= rn_d_next[r];
            end
            rn_v_reg[0] <= sq_ok_reg[SQL] || sq_lin_reg[SQL];
            rn_v_reg[1] <= sq_ok_reg[SQL];
            rn_cv_reg   <= rc;

            for (int r = 0; r < 2; r++)
            begin
                ra_num_reg[r] <= rn_n_reg[r][cbb_pkg::NW-1] ? cbb_pkg::NW'(-rn_n_reg[r])
                                                            : cbb_pkg::NW'(rn_n_reg[r]);
                ra_den_reg[r] <= rn_d_reg[r][cbb_pkg::DNW-1] ? cbb_pkg::DNW'(-rn_d_reg[r])
                                                             : cbb_pkg::DNW'(rn_d_reg[r]);
                ra_neg_reg[r] <= rn_n_reg[r][cbb_pkg::NW-1] ^ rn_d_reg[r][cbb_pkg::DNW-1];
                ra_v_reg[r]   <= rn_v_reg[r];
            end
            ra_cv_reg <= rn_cv_reg;

            for (int r = 0; r < 2; r++)
            begin
                for (int k = 0; k < DVS; k++)
                begin
                    dv_rem_reg[r][k] <= dv_rem_next[r][k];
                    dv_q_reg[r][k]   <= dv_q_next[r][k];
                    dv_ok_reg[r][k]  <= dv_ok_next[r][k];
                end
                dv_den_reg[r][0] <= ra_den_reg[r];
                dv_neg_reg[r][0] <= ra_neg_reg[r];
                for (int k = 1; k < DVS; k++)
                begin
                    dv_den_reg[r][k] <= dv_den_reg[r][k-1];
                    dv_neg_reg[r][k] <= dv_neg_reg[r][k-1];
                end
            end
            dv_cv_reg[0] <= ra_cv_reg;
            for (int k = 1; k < DVS; k++)
                dv_cv_reg[k] <= dv_cv_reg[k-1];

            // truncated toward zero: a negative quotient of magnitude zero is t = 0
            for (int r = 0; r < 2; r++)
            begin
                tt_t_reg[r]  <= dv_q_reg[r][DVS-1];
                tt_ok_reg[r] <= dv_ok_reg[r][DVS-1] &&
                                ((dv_q_reg[r][DVS-1] == '0) ||
                                 (!dv_neg_reg[r][DVS-1] &&
                                  (dv_q_reg[r][DVS-1] <= cbb_pkg::T_ONE)));
            end
            tt_cv_reg <= dv_cv_reg[DVS-1];

            for (int r = 0; r < 2; r++)
            begin
                e1_m_reg[r][0] <= dmul(tt_cv_reg.p0, tt_cv_reg.p1, tt_t_reg[r]);
                e1_m_reg[r][1] <= dmul(tt_cv_reg.p1, tt_cv_reg.p2, tt_t_reg[r]);
                e1_m_reg[r][2] <= dmul(tt_cv_reg.p2, tt_cv_reg.p3, tt_t_reg[r]);

                e2_c_reg[r][0] <= ladd(ev_cv_reg[0].p0, e1_m_reg[r][0]);
                e2_c_reg[r][1] <= ladd(ev_cv_reg[0].p1, e1_m_reg[r][1]);
                e2_c_reg[r][2] <= ladd(ev_cv_reg[0].p2, e1_m_reg[r][2]);

                e3_m_reg[r][0] <= dmul(e2_c_reg[r][0], e2_c_reg[r][1], ev_t_reg[r][1]);
                e3_m_reg[r][1] <= dmul(e2_c_reg[r][1], e2_c_reg[r][2], ev_t_reg[r][1]);
                e3_a_reg[r]    <= e2_c_reg[r][0];
                e3_b_reg[r]    <= e2_c_reg[r][1];

                e4_d_reg[r] <= ladd(e3_a_reg[r], e3_m_reg[r][0]);
                e4_e_reg[r] <= ladd(e3_b_reg[r], e3_m_reg[r][1]);

                e5_m_reg[r] <= dmul(e4_d_reg[r], e4_e_reg[r], ev_t_reg[r][3]);
                e5_d_reg[r] <= e4_d_reg[r];

                e6_v_reg[r] <= ladd(e5_d_reg[r], e5_m_reg[r]);

                ev_t_reg[r][0]  <= tt_t_reg[r];
                ev_ok_reg[r][0] <= tt_ok_reg[r];
                for (int e = 1; e < EVS; e++)
                begin
                    ev_t_reg[r][e]  <= ev_t_reg[r][e-1];
                    ev_ok_reg[r][e] <= ev_ok_reg[r][e-1];
                end
            end
            ev_cv_reg[0] <= tt_cv_reg;
            for (int e = 1; e < EVS; e++)
                ev_cv_reg[e] <= ev_cv_reg[e-1];

            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign vld_out = vld_reg;
    assign lo      = lo_reg;
    assign hi      = hi_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/cubic_bezier_bounding_box.sv =====
// Tight axis-aligned bounding box of a cubic Bezier curve, top level.
//
// curve (sink): one word holds start, both control points and end, signed Q12.4.
// box (source): one word holds min x, min y, max x, max y of the curve over t in [0,1].
// Each axis runs its own pipeline: coefficients and discriminant (3 stages),
// a 30-stage square root, root set-up (2), an 18-stage divider, a range check (1),
// three de Casteljau levels of multiply then add (6) and the min/max fold into
// the output register (1).
// A new word is taken every cycle while the output is not stalled, as the square root
// and divider are pipelined one bit per stage.
// All stages advance together; when box.valid is high and box.ready low the whole
// pipeline holds and curve.ready drops in the same cycle, so nothing is lost or
// repeated. Bubbles between words flow through as they are; a stall holds them too.
// Reset clears the valid bits; data registers are left as they are.
`default_nettype none
module cubic_bezier_bounding_box (
    input  logic         clk,
    input  logic         rst_n,
    cbb_curve_if.sink    curve,
    cbb_box_if.source    box
);

    logic en;

    assign en          = !box.valid || box.ready;
    assign curve.ready = en;

    cbb_axis u_axis_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (curve.valid),
        .p0      (curve.start_x),
        .p1      (curve.ctrl_a_x),
        .p2      (curve.ctrl_b_x),
        .p3      (curve.end_x),
        .vld_out (box.valid),
        .lo      (box.box_min_x),
        .hi      (box.box_max_x)
    );

    // same timing as x, its valid is not needed
    cbb_axis u_axis_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (curve.valid),
        .p0      (curve.start_y),
        .p1      (curve.ctrl_a_y),
        .p2      (curve.ctrl_b_y),
        .p3      (curve.end_y),
        .vld_out (),
        .lo      (box.box_min_y),
        .hi      (box.box_max_y)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/cbb_checker.sv =====
// Port-level assertions for the bounding box block and their bind.
`default_nettype none
module cbb_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input cbb_pkg::coord_t min_x,
    input cbb_pkg::coord_t min_y,
    input cbb_pkg::coord_t max_x,
    input cbb_pkg::coord_t max_y
);

    // a box never comes out inside out
    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (min_x <= max_x) && (min_y <= max_y))
        else $error("box min above max");

    // an empty output stage always lets a word in
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(min_x) && $stable(min_y)
                                     && $stable(max_x) && $stable(max_y))
        else $error("stalled box word changed");

    // nothing comes out straight after reset
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("box word valid out of reset");

endmodule

bind cubic_bezier_bounding_box cbb_checker u_cbb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (curve.ready),
    .out_valid (box.valid),
    .out_ready (box.ready),
    .min_x     (box.box_min_x),
    .min_y     (box.box_min_y),
    .max_x     (box.box_max_x),
    .max_y     (box.box_max_y)
);
`default_nettype wire

// ===== tb/cbb_box_checker.sv =====
// Checker for the bounding box block: predicts each box from accepted curve words.
`timescale 1ns / 100ps
module cbb_box_checker
    import cbb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cbb_curve_if.sink   curve,
    cbb_box_if.sink     box,
    output int          fail_count,
    output int          pending
);

    localparam int T_FRAC = 16;
    localparam int R_FRAC = 12;

    typedef struct {
        coord_t lo_x;
        coord_t lo_y;
        coord_t hi_x;
        coord_t hi_y;
    } box_word_t;

    box_word_t box_queue[$];

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint blend(longint a, longint b, longint t);
        return a + floor_shr((b - a) * t, T_FRAC);
    endfunction

    function automatic longint point_at(longint p[4], longint t);
        longint a, b, c;
        a = blend(p[0], p[1], t);
        b = blend(p[1], p[2], t);
        c = blend(p[2], p[3], t);
        return blend(blend(a, b, t), blend(b, c, t), t);
    endfunction

    function automatic void fold_root(longint p[4], longint t, inout longint lo,
                                      inout longint hi);
        longint v;
        if (t < 0 || t > (longint'(1) << T_FRAC))
            return;
        v = point_at(p, t);
        if (v < lo) lo = v;
        if (v > hi) hi = v;
    endfunction

    function automatic void axis_extent(longint p[4], output longint lo, output longint hi);
        longint a, b, c, d, s, g, den;
        g = longint'(1) << R_FRAC;
        a = p[3] - 3 * p[2] + 3 * p[1] - p[0];
        b = p[2] - 2 * p[1] + p[0];
        c = p[1] - p[0];
        lo = (p[0] < p[3]) ? p[0] : p[3];
        hi = (p[0] < p[3]) ? p[3] : p[0];
        if (a != 0)
        begin
            d = b * b - a * c;
            if (d >= 0)
            begin
                s = int_sqrt(longint'(d) << (2 * R_FRAC));
                den = a * g;
                fold_root(p, ((-b * g - s) * (longint'(1) << T_FRAC)) / den, lo, hi);
                fold_root(p, ((-b * g + s) * (longint'(1) << T_FRAC)) / den, lo, hi);
            end
        end
        else if (b != 0)
            fold_root(p, (-c * (longint'(1) << T_FRAC)) / (2 * b), lo, hi);
    endfunction

    function automatic box_word_t predict_box(coord_t sx, coord_t sy, coord_t ax, coord_t ay,
                                              coord_t bx, coord_t by, coord_t ex, coord_t ey);
        longint px[4], py[4], lo, hi;
        box_word_t w;
        px = '{longint'(sx), longint'(ax), longint'(bx), longint'(ex)};
        py = '{longint'(sy), longint'(ay), longint'(by), longint'(ey)};
        axis_extent(px, lo, hi);
        w.lo_x = coord_t'(lo);
        w.hi_x = coord_t'(hi);
        axis_extent(py, lo, hi);
        w.lo_y = coord_t'(lo);
        w.hi_y = coord_t'(hi);
        return w;
    endfunction

    initial fail_count = 0;
    initial pending = 0;

    always @(posedge clk)
    begin
        box_word_t w;
        if (rst_n && curve.valid && curve.ready)
            box_queue.push_back(predict_box(curve.start_x, curve.start_y, curve.ctrl_a_x,
                curve.ctrl_a_y, curve.ctrl_b_x, curve.ctrl_b_y, curve.end_x, curve.end_y));
        if (rst_n && box.valid && box.ready)
        begin
            if (box_queue.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected box word at %0t", $realtime);
            end
            else
            begin
                w = box_queue.pop_front();
                if (w.lo_x !== box.box_min_x || w.lo_y !== box.box_min_y ||
                    w.hi_x !== box.box_max_x || w.hi_y !== box.box_max_y)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("box mismatch: exp min %0d,%0d max %0d,%0d got min %0d,%0d max %0d,%0d",
                            w.lo_x, w.lo_y, w.hi_x, w.hi_y, box.box_min_x, box.box_min_y,
                            box.box_max_x, box.box_max_y);
                end
            end
        end
        pending = box_queue.size();
    end

endmodule

// ===== tb/cubic_bezier_bounding_box_tb.sv =====
// Testbench top: curve stimulus, box back-pressure and verdict.
`timescale 1ns / 100ps
module cubic_bezier_bounding_box_tb;
    import cbb_pkg::*;

    localparam int N_RANDOM = 850;
    localparam int QUIET_FROM = 700;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    bit   quiet;

    cbb_curve_if curve ();
    cbb_box_if   box ();

    cubic_bezier_bounding_box i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .curve (curve.sink),
        .box   (box.source)
    );

    cbb_box_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .curve      (curve.sink),
        .box        (box.sink),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic coord_t pick_coord(int mode);
        case (mode)
            0: return coord_t'(16'sh8000);
            1: return coord_t'(16'sh7fff);
            2: return coord_t'($urandom_range(0, 64)) - coord_t'(32);
            default: return coord_t'($urandom);
        endcase
    endfunction

    // drive one word and hold it until taken; inputs move at the falling edge
    task automatic send_curve(coord_t sx, coord_t sy, coord_t ax, coord_t ay,
                              coord_t bx, coord_t by, coord_t ex, coord_t ey);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            curve.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        curve.valid    <= 1'b1;
        curve.start_x  <= sx;
        curve.start_y  <= sy;
        curve.ctrl_a_x <= ax;
        curve.ctrl_a_y <= ay;
        curve.ctrl_b_x <= bx;
        curve.ctrl_b_y <= by;
        curve.end_x    <= ex;
        curve.end_y    <= ey;
        @(posedge clk);
        while (!curve.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(int mode_hi);
        coord_t v[8];
        foreach (v[k])
            v[k] = pick_coord($urandom_range(0, mode_hi) == 0 ?
                $urandom_range(0, 1) : $urandom_range(2, 3));
        send_curve(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    endtask

    // receiver stalls in bursts
    initial
    begin
        int burst;
        box.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 19);
                box.ready <= 1'b0;
                repeat (burst) @(negedge clk);
            end
            else
            begin
                box.ready <= 1'b1;
                @(negedge clk);
            end
        end
    end

    initial
    begin
        int waited;
        quiet          = 1'b0;
        rst_n          = 1'b0;
        curve.valid    = 1'b0;
        curve.start_x  = '0;
        curve.start_y  = '0;
        curve.ctrl_a_x = '0;
        curve.ctrl_a_y = '0;
        curve.ctrl_b_x = '0;
        curve.ctrl_b_y = '0;
        curve.end_x    = '0;
        curve.end_y    = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, straight and constant axes, loops, no real roots
        send_curve('0, '0, '0, '0, '0, '0, '0, '0);
        send_curve(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
                   16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        send_curve(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                   16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_curve(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                   16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_curve(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                   16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        send_curve(0, 0, 100, 300, 200, 300, 300, 0);     // straight x, quadratic-like y
        send_curve(0, 0, 300, 100, 300, 200, 0, 300);
        send_curve(0, 0, 0, 1000, 1000, 1000, 1000, 0);
        send_curve(0, 0, 600, 600, -200, 600, 400, 0);
        send_curve(-100, 50, 400, -700, -400, 900, 100, -50); // double-hump
        send_curve(0, 0, 10, 10, 20, 20, 30, 30);          // A = B = 0
        send_curve(0, 0, 30, -20, 20, 40, 30, 10);
        send_curve(0, 0, 1, 1, 1, 1, 0, 0);                 // tiny, A = 0 so a single linear root
        send_curve(5, 5, 5, 5, 5, 5, -5, -5);
        send_curve(0, 0, 100, 0, 0, 100, 100, 100);
        send_curve(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768);
        send_curve(1000, -1000, -3000, 3000, 3000, -3000, -1000, 1000);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == QUIET_FROM)
                quiet = 1'b1;
            send_random(5);
        end
        curve.valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 100000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (100) @(negedge clk);
        if (pending == 0 && fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
